@@ rtl/lruk_pkg.sv @@
package lruk_pkg;

    // Field widths of the item ports
    localparam int REQ_W    = 2;
    localparam int FRAME_W  = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int DEPTH_W    = 4;
    localparam int FRAMES_W   = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_DEPTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'd1;

    localparam logic [DEPTH_W-1:0]  HISTORY_DEPTH_RST = 4'd2;
    localparam logic [FRAMES_W-1:0] FRAMES_IN_USE_RST = 7'd64;

    // Defaults for the top level parameters
    localparam int FRAME_SLOTS_DEF = 64;
    localparam int MAX_K_DEF       = 8;
    localparam int STAMP_BITS_DEF  = 32;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ACCESS = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET_EV = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_EVICT  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_EVICTABLE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY         = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [FRAME_W-1:0] frame_sel;
        logic               evictable_flag;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  victim_frame;
        logic [COUNT_W-1:0]  evictable_count;
    } rsp_t;

    // Control of one candidate handed to the victim selector
    typedef struct packed {
        logic vld;
        logic inf;
    } cand_t;

endpackage

@@ rtl/lruk_best_sel.sv @@
module lruk_best_sel #(
    parameter int IDX_W      = 6,
    parameter int STAMP_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clr,
    input  lruk_pkg::cand_t       cand,
    input  logic [IDX_W-1:0]      idx,
    input  logic [STAMP_BITS-1:0] age,
    output logic                  found,
    output logic [IDX_W-1:0]      best_idx
);
    import lruk_pkg::*;

    logic                  found_reg;
    logic                  inf_reg;
    logic [STAMP_BITS-1:0] age_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  upd;

    // Infinite distance beats finite; within a class the older one wins,
    // strict compare keeps the lowest id on a tie.
    assign upd = cand.vld && (!found_reg || (cand.inf && !inf_reg) ||
                              (cand.inf == inf_reg && age > age_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            inf_reg   <= 1'b0;
        end
        else if (clr)
        begin
            found_reg <= 1'b0;
            inf_reg   <= 1'b0;
        end
        else if (upd)
        begin
            found_reg <= 1'b1;
            inf_reg   <= cand.inf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd && !clr)
        begin
            age_reg <= age;
            idx_reg <= idx;
        end
    end

    assign found    = found_reg;
    assign best_idx = idx_reg;

endmodule

@@ rtl/lru_k_frame_replacer.sv @@
// Channel  | Signals                   | Handshake
// ---------+---------------------------+-------------------------------------
// request  | start, busy, req          | taken when start high and busy low
// result   | done, rsp                 | valid for the one cycle done is high
// config   | cfg_we, cfg_idx, cfg_data | written when cfg_we is high
//
// Set evictable, remove and out of range requests answer in the cycle after
// they are taken; record access reads the metadata memory, then writes it.
// Evict has one comparator walk every frame's selected stamp through a
// three-step read pipeline (metadata memory, stamp memory, compare).
// Reset clears all marks and counters at once; no clearing pass is needed.
// The receiver cannot stall: each result shows on done for one cycle.
module lru_k_frame_replacer #(
    parameter int FRAME_SLOTS = lruk_pkg::FRAME_SLOTS_DEF,
    parameter int MAX_K       = lruk_pkg::MAX_K_DEF,
    parameter int STAMP_BITS  = lruk_pkg::STAMP_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  lruk_pkg::req_t                   req,
    output logic                             done,
    output lruk_pkg::rsp_t                   rsp,
    input  logic                             cfg_we,
    input  logic [lruk_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [lruk_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lruk_pkg::*;

    localparam int IDX_W = $clog2(FRAME_SLOTS);
    localparam int CNT_W = $clog2(FRAME_SLOTS + 1);
    localparam int KW    = $clog2(MAX_K + 1);
    localparam int HW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int MW    = KW + HW;
    localparam int AW    = $clog2(FRAME_SLOTS * MAX_K);
    localparam int CW    = (CNT_W > FRAMES_W) ? CNT_W : FRAMES_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REC_WR,
        S_SCAN
    } state_t;

    state_t state_reg;

    // Configuration
    logic [DEPTH_W-1:0]  depth_cfg_reg;
    logic [FRAMES_W-1:0] frames_cfg_reg;
    logic [KW-1:0]       k_eff;
    logic [CW-1:0]       frames_eff;

    // Per-frame marks and global counters
    logic [FRAME_SLOTS-1:0] present_reg;
    logic [FRAME_SLOTS-1:0] present_next;
    logic [FRAME_SLOTS-1:0] evict_reg;
    logic [FRAME_SLOTS-1:0] evict_next;
    logic [CNT_W-1:0]       total_reg;
    logic [CNT_W-1:0]       total_next;
    logic [STAMP_BITS-1:0]  stamp_reg;

    logic [IDX_W-1:0]      cur_f_reg;
    logic                  done_reg;
    logic                  done_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    // Memories: fill and head per frame, stamps per frame and slot
    logic [MW-1:0]         meta_mem [FRAME_SLOTS];
    logic [MW-1:0]         meta_q;
    logic [IDX_W-1:0]      meta_raddr;
    logic                  meta_we;
    logic [MW-1:0]         meta_wdata;
    logic [STAMP_BITS-1:0] stamp_mem [FRAME_SLOTS * MAX_K];
    logic [STAMP_BITS-1:0] stamp_q;
    logic [AW-1:0]         stamp_raddr;
    logic [AW-1:0]         stamp_waddr;
    logic                  stamp_we;

    // Scan pipeline
    logic [CNT_W-1:0]      cnt_reg;
    logic                  p1_v_reg;
    logic                  p1_cand_reg;
    logic [IDX_W-1:0]      p1_idx_reg;
    logic                  p2_v_reg;
    logic                  p2_cand_reg;
    logic                  p2_inf_reg;
    logic [IDX_W-1:0]      p2_idx_reg;

    logic                  accept;
    logic [IDX_W-1:0]      fidx;
    logic                  in_range;

    // Record access datapath
    logic [KW-1:0]         fill_cur;
    logic [HW-1:0]         head_cur;
    logic [KW-1:0]         fill_new;
    logic [HW-1:0]         head_new;
    logic [KW:0]           drop_sum;
    logic [KW:0]           slot_sum;

    // Scan datapath
    logic [KW-1:0]         fill_s;
    logic [HW-1:0]         head_s;
    logic                  inf_s;
    logic [KW:0]           pos_sum;
    logic [STAMP_BITS-1:0] age;

    cand_t                 cand;
    logic                  best_found;
    logic [IDX_W-1:0]      best_idx;
    logic                  scan_clr;
    logic                  scan_end;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;
    assign fidx   = IDX_W'(req.frame_sel);

    // Clamp K to 1..MAX_K and the frame limit to FRAME_SLOTS
    always_comb
    begin
        if (depth_cfg_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (int'(depth_cfg_reg) > MAX_K)
        begin
            k_eff = KW'(MAX_K);
        end
        else
        begin
            k_eff = KW'(depth_cfg_reg);
        end
        if (int'(frames_cfg_reg) > FRAME_SLOTS)
        begin
            frames_eff = CW'(FRAME_SLOTS);
        end
        else
        begin
            frames_eff = CW'(frames_cfg_reg);
        end
    end

    assign in_range = (CW'(req.frame_sel) < frames_eff);

    // Record access: drop the oldest entries down to K-1, then append
    always_comb
    begin
        fill_cur = present_reg[cur_f_reg] ? meta_q[MW-1:HW] : '0;
        head_cur = present_reg[cur_f_reg] ? meta_q[HW-1:0] : '0;
        fill_new = fill_cur;
        head_new = head_cur;
        drop_sum = '0;
        if (fill_cur >= k_eff)
        begin
            drop_sum = (KW+1)'(head_cur) + (KW+1)'(fill_cur) - (KW+1)'(k_eff)
                       + (KW+1)'(1);
            if (int'(drop_sum) >= MAX_K)
            begin
                drop_sum = drop_sum - (KW+1)'(MAX_K);
            end
            head_new = HW'(drop_sum);
            fill_new = k_eff - KW'(1);
        end
        slot_sum = (KW+1)'(head_new) + (KW+1)'(fill_new);
        if (int'(slot_sum) >= MAX_K)
        begin
            slot_sum = slot_sum - (KW+1)'(MAX_K);
        end
    end

    assign meta_we     = (state_reg == S_REC_WR);
    assign meta_wdata  = {KW'(fill_new + KW'(1)), head_new};
    assign stamp_we    = (state_reg == S_REC_WR);
    assign stamp_waddr = AW'(cur_f_reg * MAX_K) + AW'(slot_sum);
    assign meta_raddr  = (state_reg == S_IDLE) ? fidx : IDX_W'(cnt_reg);

    // Scan stage one: pick the oldest kept stamp or the K-th most recent
    always_comb
    begin
        fill_s  = meta_q[MW-1:HW];
        head_s  = meta_q[HW-1:0];
        inf_s   = (fill_s < k_eff);
        pos_sum = (KW+1)'(head_s);
        if (!inf_s)
        begin
            pos_sum = (KW+1)'(head_s) + (KW+1)'(fill_s) - (KW+1)'(k_eff);
        end
        if (int'(pos_sum) >= MAX_K)
        begin
            pos_sum = pos_sum - (KW+1)'(MAX_K);
        end
    end

    assign stamp_raddr = AW'(p1_idx_reg * MAX_K) + AW'(pos_sum);

    // Scan stage two: age against the running stamp, wrapping
    assign age      = stamp_reg - stamp_q;
    assign cand.vld = p2_v_reg && p2_cand_reg;
    assign cand.inf = p2_inf_reg;
    assign scan_clr = accept && (req.req_type == REQ_EVICT);
    assign scan_end = (state_reg == S_SCAN) && (int'(cnt_reg) == FRAME_SLOTS) &&
                      !p1_v_reg && !p2_v_reg;

    lruk_best_sel #(
        .IDX_W      (IDX_W),
        .STAMP_BITS (STAMP_BITS)
    ) u_best_sel (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (scan_clr),
        .cand     (cand),
        .idx      (p2_idx_reg),
        .age      (age),
        .found    (best_found),
        .best_idx (best_idx)
    );

    // Marks, evictable total and the answer for the item in hand
    always_comb
    begin
        present_next = present_reg;
        evict_next   = evict_reg;
        total_next   = total_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.status       = ST_OK;
                    rsp_next.victim_frame = '0;
                    if (req.req_type != REQ_EVICT && !in_range)
                    begin
                        rsp_next.status = ST_OUT_OF_RANGE;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        unique case (req.req_type)
                            REQ_ACCESS: ;   // answered after the write cycle
                            REQ_SET_EV:
                            begin
                                done_next = 1'b1;
                                if (present_reg[fidx] &&
                                    evict_reg[fidx] != req.evictable_flag)
                                begin
                                    evict_next[fidx] = req.evictable_flag;
                                    if (req.evictable_flag)
                                    begin
                                        total_next = total_reg + CNT_W'(1);
                                    end
                                    else
                                    begin
                                        total_next = total_reg - CNT_W'(1);
                                    end
                                end
                            end
                            REQ_REMOVE:
                            begin
                                done_next = 1'b1;
                                if (present_reg[fidx])
                                begin
                                    if (!evict_reg[fidx])
                                    begin
                                        rsp_next.status = ST_NOT_EVICTABLE;
                                    end
                                    else
                                    begin
                                        present_next[fidx] = 1'b0;
                                        evict_next[fidx]   = 1'b0;
                                        total_next = total_reg - CNT_W'(1);
                                    end
                                end
                            end
                            REQ_EVICT: ;    // answered when the scan ends
                            default: ;
                        endcase
                    end
                end
            end

            S_REC_WR:
            begin
                present_next[cur_f_reg] = 1'b1;
                done_next               = 1'b1;
            end

            S_SCAN:
            begin
                if (scan_end)
                begin
                    done_next = 1'b1;
                    if (best_found)
                    begin
                        present_next[best_idx] = 1'b0;
                        evict_next[best_idx]   = 1'b0;
                        total_next             = total_reg - CNT_W'(1);
                        rsp_next.victim_frame  = FRAME_W'(best_idx);
                    end
                    else
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                end
            end

            default: ;
        endcase
        rsp_next.evictable_count = COUNT_W'(total_next);
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[cur_f_reg] <= meta_wdata;
        end
        meta_q <= meta_mem[meta_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= stamp_reg;
        end
        stamp_q <= stamp_mem[stamp_raddr];
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= IDX_W'(cnt_reg);
        p2_idx_reg <= p1_idx_reg;
        p2_inf_reg <= inf_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            depth_cfg_reg  <= HISTORY_DEPTH_RST;
            frames_cfg_reg <= FRAMES_IN_USE_RST;
            present_reg    <= '0;
            evict_reg      <= '0;
            total_reg      <= '0;
            stamp_reg      <= '0;
            cur_f_reg      <= '0;
            done_reg       <= 1'b0;
            rsp_reg        <= '0;
            cnt_reg        <= '0;
            p1_v_reg       <= 1'b0;
            p1_cand_reg    <= 1'b0;
            p2_v_reg       <= 1'b0;
            p2_cand_reg    <= 1'b0;
        end
        else
        begin
            present_reg <= present_next;
            evict_reg   <= evict_next;
            total_reg   <= total_next;
            done_reg    <= done_next;
            rsp_reg     <= rsp_next;

            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_HISTORY_DEPTH: depth_cfg_reg  <= DEPTH_W'(cfg_data);
                    CFG_FRAMES_IN_USE: frames_cfg_reg <= FRAMES_W'(cfg_data);
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur_f_reg <= fidx;
                        // Out of range items answer at once and stay idle
                        priority if (req.req_type != REQ_EVICT && !in_range)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (req.req_type == REQ_ACCESS)
                        begin
                            state_reg <= S_REC_WR;
                        end
                        else if (req.req_type == REQ_EVICT)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_REC_WR:
                begin
                    // Metadata and stamp are written this cycle
                    stamp_reg <= stamp_reg + STAMP_BITS'(1);
                    state_reg <= S_IDLE;
                end

                S_SCAN:
                begin
                    // Issue one frame per cycle, then drain the pipeline
                    if (int'(cnt_reg) < FRAME_SLOTS)
                    begin
                        p1_v_reg    <= 1'b1;
                        p1_cand_reg <= present_reg[IDX_W'(cnt_reg)] &&
                                       evict_reg[IDX_W'(cnt_reg)];
                        cnt_reg     <= cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        p1_v_reg <= 1'b0;
                    end
                    p2_v_reg    <= p1_v_reg;
                    p2_cand_reg <= p1_cand_reg;

                    if (scan_end)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/lruk_checker.sv @@
module lruk_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input lruk_pkg::req_t                  req,
    input logic                            done,
    input lruk_pkg::rsp_t                  rsp,
    input logic                            cfg_we,
    input logic [lruk_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input logic [lruk_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lruk_pkg::*;

    // Every multi-cycle item ends with its result
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // A victim is named only by a successful evict
    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_OK |-> rsp.victim_frame == '0)
        else $error("victim set on a failed request");

    // An empty evict means no evictable frames remain
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == ST_EMPTY |-> rsp.evictable_count == '0)
        else $error("empty evict with evictable frames");

endmodule

bind lru_k_frame_replacer lruk_checker u_lruk_checker (.*);
